// ===== sv/dcus_pkg.sv =====
package dcus_pkg;

    // channel counts of the two dacs
    localparam int COIL_CHANNELS = 4;
    localparam int FAN_CHANNELS  = 4;

    // request codes
    localparam logic [1:0] REQ_SET_COIL = 2'd0;
    localparam logic [1:0] REQ_SET_FAN  = 2'd1;
    localparam logic [1:0] REQ_POLL     = 2'd2;
    localparam logic [1:0] REQ_DONE     = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SCALE_FACTOR = 3'd0;
    localparam logic [2:0] REG_MAX_DAC      = 3'd1;
    localparam logic [2:0] REG_MAX_FAN      = 3'd2;
    localparam logic [2:0] REG_LOAD_CMD     = 3'd3;
    localparam logic [2:0] REG_X_COIL       = 3'd4;
    localparam logic [2:0] REG_Y_COIL       = 3'd5;

    localparam int PADDR_W = 5;

    localparam logic [14:0] VOLT_MAX = 15'h7fff;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [1:0]         channel;
        logic signed [15:0] voltage;
    } t_req;

    typedef struct packed {
        logic       send_valid;
        logic       target_dac;
        logic [7:0] cmd_byte;
        logic [7:0] data_high;
        logic [7:0] data_low;
        logic       x_dir_n;
        logic       y_dir_n;
        logic       bus_busy_out;
    } t_result;

    typedef struct packed {
        logic [15:0] scale_factor;
        logic [14:0] dac_clamp;
        logic [14:0] max_fan_voltage;
        logic [7:0]  load_command;
        logic [1:0]  x_coil_channel;
        logic [1:0]  y_coil_channel;
    } t_cfg;

endpackage

// ===== sv/dcus_cfg.sv =====
module dcus_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcus_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output dcus_pkg::t_cfg                o_cfg
);

    dcus_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[dcus_pkg::PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_factor    <= 16'd0;
            r_cfg.dac_clamp       <= dcus_pkg::VOLT_MAX;
            r_cfg.max_fan_voltage <= dcus_pkg::VOLT_MAX;
            r_cfg.load_command    <= 8'd0;
            r_cfg.x_coil_channel  <= 2'd0;
            r_cfg.y_coil_channel  <= 2'd1;
        end else if (wr_en) begin
            case (reg_idx)
                dcus_pkg::REG_SCALE_FACTOR: r_cfg.scale_factor    <= pwdata[15:0];
                dcus_pkg::REG_MAX_DAC:      r_cfg.dac_clamp       <= pwdata[14:0];
                dcus_pkg::REG_MAX_FAN:      r_cfg.max_fan_voltage <= pwdata[14:0];
                dcus_pkg::REG_LOAD_CMD:     r_cfg.load_command    <= pwdata[7:0];
                dcus_pkg::REG_X_COIL:       r_cfg.x_coil_channel  <= pwdata[1:0];
                dcus_pkg::REG_Y_COIL:       r_cfg.y_coil_channel  <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dcus_pkg::REG_SCALE_FACTOR: prdata = {16'd0, r_cfg.scale_factor};
            dcus_pkg::REG_MAX_DAC:      prdata = {17'd0, r_cfg.dac_clamp};
            dcus_pkg::REG_MAX_FAN:      prdata = {17'd0, r_cfg.max_fan_voltage};
            dcus_pkg::REG_LOAD_CMD:     prdata = {24'd0, r_cfg.load_command};
            dcus_pkg::REG_X_COIL:       prdata = {30'd0, r_cfg.x_coil_channel};
            dcus_pkg::REG_Y_COIL:       prdata = {30'd0, r_cfg.y_coil_channel};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/dcus_core.sv =====
module dcus_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dcus_pkg::t_req    i_req,
    input  dcus_pkg::t_cfg    i_cfg,
    output logic              o_result_valid,
    output dcus_pkg::t_result o_result
);

    // input register
    logic              r_in_valid;
    dcus_pkg::t_req    r_in;

    // channel state
    logic [14:0] r_coil_value [dcus_pkg::COIL_CHANNELS];
    logic [14:0] n_coil_value [dcus_pkg::COIL_CHANNELS];
    logic [dcus_pkg::COIL_CHANNELS-1:0] r_coil_pending, n_coil_pending;
    logic [14:0] r_fan_value [dcus_pkg::FAN_CHANNELS];
    logic [14:0] n_fan_value [dcus_pkg::FAN_CHANNELS];
    logic [dcus_pkg::FAN_CHANNELS-1:0] r_fan_pending, n_fan_pending;
    logic r_bus_busy, n_bus_busy;
    logic r_x_dir, n_x_dir;
    logic r_y_dir, n_y_dir;

    // result register
    logic              r_out_valid;
    dcus_pkg::t_result r_res, n_res;

    // poll path
    logic        sel_found;
    logic        sel_fan;
    logic [1:0]  sel_ch;
    logic [14:0] sel_value;
    logic [14:0] clamped;
    logic [30:0] product;
    logic [15:0] data_word;

    // coil / fan set path
    logic        neg;
    logic [15:0] abs_v;
    logic [14:0] coil_mag;
    logic        fan_at_max;

    assign neg        = r_in.voltage[15];
    assign abs_v      = neg ? (16'd0 - r_in.voltage) : r_in.voltage;
    assign coil_mag   = abs_v[15] ? dcus_pkg::VOLT_MAX : abs_v[14:0];
    assign fan_at_max = r_in.voltage >= $signed({1'b0, i_cfg.max_fan_voltage});

    // lowest pending coil first, then lowest pending fan
    always_comb begin
        sel_found = 1'b0;
        sel_fan   = 1'b0;
        sel_ch    = 2'd0;
        sel_value = 15'd0;
        for (int i = dcus_pkg::FAN_CHANNELS - 1; i >= 0; i--) begin
            if (r_fan_pending[i]) begin
                sel_found = 1'b1;
                sel_fan   = 1'b1;
                sel_ch    = 2'(i);
                sel_value = r_fan_value[i];
            end
        end
        for (int i = dcus_pkg::COIL_CHANNELS - 1; i >= 0; i--) begin
            if (r_coil_pending[i]) begin
                sel_found = 1'b1;
                sel_fan   = 1'b0;
                sel_ch    = 2'(i);
                sel_value = r_coil_value[i];
            end
        end
    end

    assign clamped   = (sel_value > i_cfg.dac_clamp) ? i_cfg.dac_clamp : sel_value;
    assign product   = 31'(i_cfg.scale_factor) * 31'(clamped);
    assign data_word = {product[27:16], 4'd0};

    always_comb begin
        n_coil_value   = r_coil_value;
        n_coil_pending = r_coil_pending;
        n_fan_value    = r_fan_value;
        n_fan_pending  = r_fan_pending;
        n_bus_busy     = r_bus_busy;
        n_x_dir        = r_x_dir;
        n_y_dir        = r_y_dir;
        n_res          = '0;

        case (r_in.req_type)
            dcus_pkg::REQ_SET_COIL: begin
                for (int i = 0; i < dcus_pkg::COIL_CHANNELS; i++) begin
                    if (r_in.channel == 2'(i)) begin
                        n_coil_value[i]   = coil_mag;
                        n_coil_pending[i] = 1'b1;
                        if (r_in.channel == i_cfg.x_coil_channel) begin
                            n_x_dir = ~neg;
                        end else if (r_in.channel == i_cfg.y_coil_channel) begin
                            n_y_dir = ~neg;
                        end
                    end
                end
            end
            dcus_pkg::REQ_SET_FAN: begin
                for (int i = 0; i < dcus_pkg::FAN_CHANNELS; i++) begin
                    if (r_in.channel == 2'(i)) begin
                        if (fan_at_max) begin
                            n_fan_value[i]   = i_cfg.max_fan_voltage;
                            n_fan_pending[i] = 1'b1;
                        end else if (neg) begin
                            n_fan_pending[i] = 1'b0;
                        end else begin
                            n_fan_value[i]   = r_in.voltage[14:0];
                            n_fan_pending[i] = 1'b1;
                        end
                    end
                end
            end
            dcus_pkg::REQ_POLL: begin
                if (!r_bus_busy && sel_found) begin
                    n_res.send_valid = 1'b1;
                    n_res.target_dac = sel_fan;
                    n_res.cmd_byte   = {6'd0, sel_ch} | i_cfg.load_command;
                    n_res.data_high  = data_word[15:8];
                    n_res.data_low   = data_word[7:0];
                    n_bus_busy       = 1'b1;
                    for (int i = 0; i < dcus_pkg::COIL_CHANNELS; i++) begin
                        if (!sel_fan && sel_ch == 2'(i)) begin
                            n_coil_pending[i] = 1'b0;
                        end
                    end
                    for (int i = 0; i < dcus_pkg::FAN_CHANNELS; i++) begin
                        if (sel_fan && sel_ch == 2'(i)) begin
                            n_fan_pending[i] = 1'b0;
                        end
                    end
                end
            end
            dcus_pkg::REQ_DONE: begin
                n_bus_busy = 1'b0;
            end
            default: begin
            end
        endcase

        n_res.x_dir_n      = n_x_dir;
        n_res.y_dir_n      = n_y_dir;
        n_res.bus_busy_out = n_bus_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_coil_pending <= '0;
            r_fan_pending  <= '0;
            r_bus_busy     <= 1'b0;
            r_x_dir        <= 1'b1;
            r_y_dir        <= 1'b1;
            for (int i = 0; i < dcus_pkg::COIL_CHANNELS; i++) begin
                r_coil_value[i] <= 15'd0;
            end
            for (int i = 0; i < dcus_pkg::FAN_CHANNELS; i++) begin
                r_fan_value[i] <= 15'd0;
            end
        end else begin
            r_in_valid  <= i_in_valid;
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_coil_value   <= n_coil_value;
                r_coil_pending <= n_coil_pending;
                r_fan_value    <= n_fan_value;
                r_fan_pending  <= n_fan_pending;
                r_bus_busy     <= n_bus_busy;
                r_x_dir        <= n_x_dir;
                r_y_dir        <= n_y_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid) begin
            r_in <= i_req;
        end
        if (r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_res;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> r_out_valid)
        else $error("result strobe missing after registered item");

    a_send_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.send_valid) |-> (r_res.bus_busy_out && r_bus_busy))
        else $error("command sent without bus marked busy");

    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.bus_busy_out == r_bus_busy))
        else $error("reported bus state differs from held state");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.send_valid) |->
            (r_res.cmd_byte == 8'd0 && r_res.data_high == 8'd0 &&
             r_res.data_low == 8'd0 && !r_res.target_dac))
        else $error("command fields not cleared when nothing sent");

endmodule

// ===== sv/dac_channel_update_scheduler.sv =====
// an accepted item is captured in the input register, and its result and strobe
// are then captured in the result register
// throughput: one item per cycle, busy never rises, set by the single process stage
// the multiply of scale factor by the clamped voltage sits in that one stage
// reset: i_rst_n synchronous active low, clears pending marks, frees the bus,
// sets both directions positive and loads register defaults; no receiver stall
module dac_channel_update_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          start,
    output logic                          busy,
    input  dcus_pkg::t_req                i_req,
    output logic                          o_result_valid,
    output dcus_pkg::t_result             o_result,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcus_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    dcus_pkg::t_cfg cfg;
    logic           in_accept;

    // every item is taken: state reads and writes stay in the single process stage
    assign busy      = 1'b0;
    assign in_accept = start & ~busy;

    // configuration registers
    dcus_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register, channel state, poll selection, scaling and result register
    dcus_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_accept),
        .i_req          (i_req),
        .i_cfg          (cfg),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
